@@ rtl/qvr_pkg.sv @@
`default_nettype none

package qvr_pkg;

   // Fixed-point widths along the datapath.
   localparam int QUAT_W  = 16;               // Q2.14 quaternion component
   localparam int COORD_W = 32;               // Q16.16 coordinate
   localparam int DIFF_W  = COORD_W + 1;      // vertex minus pivot, exact
   localparam int PROD1_W = DIFF_W + QUAT_W;  // q * d partial product
   localparam int SUM1_W  = PROD1_W + 1;      // three-term sum of q * d
   localparam int T_W     = SUM1_W - 14;      // rounded q * d component
   localparam int PROD2_W = T_W + QUAT_W;     // t * conj(q) partial product
   localparam int SUM2_W  = PROD2_W + 2;      // four-term sum of t * conj(q)
   localparam int R_W     = SUM2_W - 14;      // rounded rotated offset
   localparam int OUT_W   = R_W + 1;          // rotated offset plus pivot
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic signed [QUAT_W-1:0] QUAT_ONE = 16'sd16384;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_QUAT_W  = 3'd0,
      REG_QUAT_X  = 3'd1,
      REG_QUAT_Y  = 3'd2,
      REG_QUAT_Z  = 3'd3,
      REG_PIVOT_X = 3'd4,
      REG_PIVOT_Y = 3'd5,
      REG_PIVOT_Z = 3'd6
   } reg_index_type;

endpackage

`default_nettype wire

@@ rtl/quaternion_vertex_rotate.sv @@
// Throughput: one item per cycle while rsp_stall is low, through a six-stage
// pipeline that holds a stage only where it is full and the stage after it cannot advance.
// Reset: synchronous, active high; clears all valid bits, sets quat_w to 1.0
// and the other quaternion components and the pivot to zero. No clearing pass.
`default_nettype none

module quaternion_vertex_rotate
   import qvr_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   // Input items: one vertex each.
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic signed [COORD_W-1:0]    req_in_x,
   input  wire logic signed [COORD_W-1:0]    req_in_y,
   input  wire logic signed [COORD_W-1:0]    req_in_z,
   // Result items: one rotated vertex each.
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic signed [COORD_W-1:0]         rsp_out_x,
   output logic signed [COORD_W-1:0]         rsp_out_y,
   output logic signed [COORD_W-1:0]         rsp_out_z,
   // Configuration writes.
   input  wire logic                         csr_we,
   input  wire logic [CSR_IDX_W-1:0]         csr_index,
   input  wire logic [CSR_DATA_W-1:0]        csr_wdata
);

   localparam int NUM_STAGES = 6;

   // Quaternion components are indexed w, x, y, z and coordinates x, y, z.
   logic signed [QUAT_W-1:0]  quat_ff  [4];
   logic signed [COORD_W-1:0] pivot_ff [3];

   // Configuration registers. The user must write them only while the pipeline is empty
   // (the block does not enforce this), so every stage can read them directly.
   always_ff @(posedge clock) begin
      if (reset) begin
         quat_ff[0]  <= QUAT_ONE;
         quat_ff[1]  <= '0;
         quat_ff[2]  <= '0;
         quat_ff[3]  <= '0;
         pivot_ff[0] <= '0;
         pivot_ff[1] <= '0;
         pivot_ff[2] <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_QUAT_W:  quat_ff[0]  <= csr_wdata[QUAT_W-1:0];
            REG_QUAT_X:  quat_ff[1]  <= csr_wdata[QUAT_W-1:0];
            REG_QUAT_Y:  quat_ff[2]  <= csr_wdata[QUAT_W-1:0];
            REG_QUAT_Z:  quat_ff[3]  <= csr_wdata[QUAT_W-1:0];
            REG_PIVOT_X: pivot_ff[0] <= csr_wdata[COORD_W-1:0];
            REG_PIVOT_Y: pivot_ff[1] <= csr_wdata[COORD_W-1:0];
            REG_PIVOT_Z: pivot_ff[2] <= csr_wdata[COORD_W-1:0];
            default: ;
         endcase
      end
   end

   // Flow control. A stage may load when it is empty or when the stage after
   // it loads in the same cycle, so bubbles are squeezed out under a stall.
   logic [NUM_STAGES:1] valid_ff;
   logic [NUM_STAGES:1] valid_in;
   logic [NUM_STAGES:1] load;

   always_comb begin
      load[NUM_STAGES] = !valid_ff[NUM_STAGES] || !rsp_stall;
      for (int k = NUM_STAGES - 1; k >= 1; k--) begin
         load[k] = !valid_ff[k] || load[k+1];
      end
      valid_in[1] = load[1] ? req_valid : valid_ff[1];
      for (int k = 2; k <= NUM_STAGES; k++) begin
         valid_in[k] = load[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !load[1];
   assign rsp_valid = valid_ff[NUM_STAGES];

   // Stage 1: offset from the pivot, exact at 33 bits.
   logic signed [DIFF_W-1:0] diff_ff [3];
   logic signed [DIFF_W-1:0] diff_in [3];

   always_comb begin
      diff_in[0] = DIFF_W'(req_in_x) - DIFF_W'(pivot_ff[0]);
      diff_in[1] = DIFF_W'(req_in_y) - DIFF_W'(pivot_ff[1]);
      diff_in[2] = DIFF_W'(req_in_z) - DIFF_W'(pivot_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (load[1]) begin
         diff_ff <= diff_in;
      end
   end

   // Stage 2: every product of a quaternion component with an offset
   // coordinate; all twelve are used by q * d.
   logic signed [PROD1_W-1:0] prod1_ff [4][3];
   logic signed [PROD1_W-1:0] prod1_in [4][3];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 3; j++) begin
            prod1_in[i][j] = PROD1_W'(quat_ff[i]) * PROD1_W'(diff_ff[j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load[2]) begin
         prod1_ff <= prod1_in;
      end
   end

   // Stage 3: sums of q * d with round half up to scale 2^-16.
   logic signed [T_W-1:0]    t_ff [4];
   logic signed [T_W-1:0]    t_in [4];
   logic signed [SUM1_W-1:0] sum1 [4];

   always_comb begin
      sum1[0] = -SUM1_W'(prod1_ff[1][0]) - SUM1_W'(prod1_ff[2][1])
                - SUM1_W'(prod1_ff[3][2]);
      sum1[1] =  SUM1_W'(prod1_ff[0][0]) + SUM1_W'(prod1_ff[2][2])
                - SUM1_W'(prod1_ff[3][1]);
      sum1[2] =  SUM1_W'(prod1_ff[0][1]) - SUM1_W'(prod1_ff[1][2])
                + SUM1_W'(prod1_ff[3][0]);
      sum1[3] =  SUM1_W'(prod1_ff[0][2]) + SUM1_W'(prod1_ff[1][1])
                - SUM1_W'(prod1_ff[2][0]);
      for (int i = 0; i < 4; i++) begin
         sum1[i] = sum1[i] + SUM1_W'(8192);
         t_in[i] = sum1[i][SUM1_W-1:14];
      end
   end

   always_ff @(posedge clock) begin
      if (load[3]) begin
         t_ff <= t_in;
      end
   end

   // Stage 4: the twelve products of t with conj(q) that reach the vector
   // part. Index [row][term] follows the sums in stage 5.
   logic signed [PROD2_W-1:0] prod2_ff [3][4];
   logic signed [PROD2_W-1:0] prod2_in [3][4];

   always_comb begin
      // x row: tw*qx, tx*qw, ty*qz, tz*qy
      prod2_in[0][0] = PROD2_W'(t_ff[0]) * PROD2_W'(quat_ff[1]);
      prod2_in[0][1] = PROD2_W'(t_ff[1]) * PROD2_W'(quat_ff[0]);
      prod2_in[0][2] = PROD2_W'(t_ff[2]) * PROD2_W'(quat_ff[3]);
      prod2_in[0][3] = PROD2_W'(t_ff[3]) * PROD2_W'(quat_ff[2]);
      // y row: tw*qy, tx*qz, ty*qw, tz*qx
      prod2_in[1][0] = PROD2_W'(t_ff[0]) * PROD2_W'(quat_ff[2]);
      prod2_in[1][1] = PROD2_W'(t_ff[1]) * PROD2_W'(quat_ff[3]);
      prod2_in[1][2] = PROD2_W'(t_ff[2]) * PROD2_W'(quat_ff[0]);
      prod2_in[1][3] = PROD2_W'(t_ff[3]) * PROD2_W'(quat_ff[1]);
      // z row: tw*qz, tx*qy, ty*qx, tz*qw
      prod2_in[2][0] = PROD2_W'(t_ff[0]) * PROD2_W'(quat_ff[3]);
      prod2_in[2][1] = PROD2_W'(t_ff[1]) * PROD2_W'(quat_ff[2]);
      prod2_in[2][2] = PROD2_W'(t_ff[2]) * PROD2_W'(quat_ff[1]);
      prod2_in[2][3] = PROD2_W'(t_ff[3]) * PROD2_W'(quat_ff[0]);
   end

   always_ff @(posedge clock) begin
      if (load[4]) begin
         prod2_ff <= prod2_in;
      end
   end

   // Stage 5: sums of t * conj(q), rounded the same way as in stage 3.
   logic signed [R_W-1:0]    r_ff [3];
   logic signed [R_W-1:0]    r_in [3];
   logic signed [SUM2_W-1:0] sum2 [3];

   always_comb begin
      sum2[0] = -SUM2_W'(prod2_ff[0][0]) + SUM2_W'(prod2_ff[0][1])
                - SUM2_W'(prod2_ff[0][2]) + SUM2_W'(prod2_ff[0][3]);
      sum2[1] = -SUM2_W'(prod2_ff[1][0]) + SUM2_W'(prod2_ff[1][1])
                + SUM2_W'(prod2_ff[1][2]) - SUM2_W'(prod2_ff[1][3]);
      sum2[2] = -SUM2_W'(prod2_ff[2][0]) - SUM2_W'(prod2_ff[2][1])
                + SUM2_W'(prod2_ff[2][2]) + SUM2_W'(prod2_ff[2][3]);
      for (int i = 0; i < 3; i++) begin
         sum2[i] = sum2[i] + SUM2_W'(8192);
         r_in[i] = sum2[i][SUM2_W-1:14];
      end
   end

   always_ff @(posedge clock) begin
      if (load[5]) begin
         r_ff <= r_in;
      end
   end

   // Stage 6: add the pivot back and saturate to the coordinate range. This
   // is also the output register, so earlier stages can still take items while
   // a result waits on rsp_stall, until they are full.
   localparam logic signed [OUT_W-1:0] COORD_MAX = OUT_W'(2147483647);
   localparam logic signed [OUT_W-1:0] COORD_MIN = -OUT_W'(64'sd2147483648);

   logic signed [COORD_W-1:0] out_ff [3];
   logic signed [COORD_W-1:0] out_in [3];
   logic signed [OUT_W-1:0]   full_sum [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         full_sum[i] = OUT_W'(r_ff[i]) + OUT_W'(pivot_ff[i]);
         if (full_sum[i] > COORD_MAX) begin
            out_in[i] = COORD_MAX[COORD_W-1:0];
         end else if (full_sum[i] < COORD_MIN) begin
            out_in[i] = COORD_MIN[COORD_W-1:0];
         end else begin
            out_in[i] = full_sum[i][COORD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load[6]) begin
         out_ff <= out_in;
      end
   end

   assign rsp_out_x = out_ff[0];
   assign rsp_out_y = out_ff[1];
   assign rsp_out_z = out_ff[2];

`ifndef ASSERT_OFF
   // With the result side open, the whole pipeline advances.
   a_no_stall_when_open: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("input stalled although result side is not stalled");

   // An accepted item always lands in the first stage.
   a_accept_fills_s1: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> valid_ff[1])
      else $error("accepted item lost at stage 1");

   // A stall at the input only comes from a full first stage with a full, stalled output.
   a_stall_means_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (valid_ff[1] && rsp_valid && rsp_stall))
      else $error("input stalled with room in the pipeline");

   // An item in stage 5 moves into the output register when it may load.
   a_s5_to_out: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[5] && load[6]) |=> rsp_valid)
      else $error("item lost between stage 5 and output");

   // Reset leaves quat_w at 1.0 and quat_x at zero, as for the identity rotation.
   a_reset_identity: assert property (@(posedge clock)
      reset |=> (quat_ff[0] == QUAT_ONE && quat_ff[1] == '0))
      else $error("quaternion not at identity after reset");
`endif

endmodule

`default_nettype wire
